FILE: sv/ctps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctps_pkg
// Shared widths, register codes, reset values and helpers for the camera
// tilt/pan shot sequencer.
// ----------------------------------------------------------------------------
package ctps_pkg;

    localparam int TILT_W      = 12;
    localparam int TBL_ENTRIES = 4;
    localparam int TBL_IDX_W   = 2;
    localparam int TBL_W       = TILT_W * TBL_ENTRIES;
    localparam int STEP_W      = 8;
    localparam int MS_W        = 16;
    localparam int PULSE_W     = 12;
    localparam int PHASE_W     = 3;
    localparam int POS_W       = 3;   // tilt index plus one, up to the max position count
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 48;

    localparam int TILT_POSITIONS_DEF = 4;
    localparam int RAMP_PERIOD_MS_DEF = 10;

    localparam logic [MS_W-1:0] POLL_MS = 16'd10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TILT_TABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_PAUSE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHUTTER      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AFTER_SHOT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAN_DRIVE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PAN_MS       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PAN_NEUTRAL  = 3'd7;

    // reset values
    localparam logic [TBL_W-1:0]   RST_TILT_TABLE   = 48'd1500;
    localparam logic [STEP_W-1:0]  RST_RAMP_STEP    = 8'd10;
    localparam logic [MS_W-1:0]    RST_SETTLE_PAUSE = 16'd1000;
    localparam logic [MS_W-1:0]    RST_SHUTTER      = 16'd500;
    localparam logic [MS_W-1:0]    RST_AFTER_SHOT   = 16'd500;
    localparam logic [PULSE_W-1:0] RST_PAN_DRIVE    = 12'd1600;
    localparam logic [MS_W-1:0]    RST_PAN_MS       = 16'd300;
    localparam logic [PULSE_W-1:0] RST_PAN_NEUTRAL  = 12'd1500;
    localparam logic [TILT_W-1:0]  RST_TILT         = RST_TILT_TABLE[TILT_W-1:0];

    typedef struct packed {
        logic [TBL_W-1:0]   tilt_table;
        logic [STEP_W-1:0]  ramp_step;
        logic [MS_W-1:0]    settle_pause_ms;
        logic [MS_W-1:0]    shutter_ms;
        logic [MS_W-1:0]    after_shot_ms;
        logic [PULSE_W-1:0] pan_drive_us;
        logic [MS_W-1:0]    pan_ms;
        logic [PULSE_W-1:0] pan_neutral_us;
    } t_cfg;

    // sequencer outputs as they stand after one tick
    typedef struct packed {
        logic [PULSE_W-1:0] pan_us;
        logic               shutter;
        logic [PHASE_W-1:0] phase;
    } t_shot_view;

    // entries past the table read as zero
    function automatic logic [TILT_W-1:0] table_entry(input logic [TBL_W-1:0] tbl,
                                                      input logic [POS_W-1:0] idx);
        logic [TILT_W-1:0] ent;
        ent = '0;
        if (idx < POS_W'(TBL_ENTRIES)) begin
            ent = tbl[TILT_W*idx[TBL_IDX_W-1:0] +: TILT_W];
        end
        return ent;
    endfunction

    // a delay of d ms leaves d-1 idle ticks
    function automatic logic [MS_W-1:0] set_wait(input logic [MS_W-1:0] d);
        return (d == '0) ? '0 : d - MS_W'(1);
    endfunction

endpackage

FILE: sv/ctps_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctps_if
// Valid/ready channels: tick input, shot result output, config writes.
// ----------------------------------------------------------------------------
interface ctps_tick_if;
    logic valid;
    logic ready;
    logic tick;
    modport source (output valid, output tick, input ready);
    modport sink   (input valid, input tick, output ready);
endinterface

interface ctps_shot_if import ctps_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [TILT_W-1:0]  tilt_pulse_us;
    logic [PULSE_W-1:0] pan_pulse_us;
    logic               shutter_on;
    logic [PHASE_W-1:0] phase;
    modport source (output valid, output tilt_pulse_us, output pan_pulse_us,
                    output shutter_on, output phase, input ready);
    modport sink   (input valid, input tilt_pulse_us, input pan_pulse_us,
                    input shutter_on, input phase, output ready);
endinterface

interface ctps_cfg_if import ctps_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/ctps_ramp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctps_ramp
// Tilt pulse ramp: every ramp period, step toward the table target.
// ----------------------------------------------------------------------------
module ctps_ramp import ctps_pkg::*; #(
    parameter int RAMP_PERIOD_MS = RAMP_PERIOD_MS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic [TBL_W-1:0]     i_tilt_table,
    input  logic [STEP_W-1:0]    i_ramp_step,
    input  logic [TBL_IDX_W-1:0] i_tilt_index,
    output logic [TILT_W-1:0]    o_tilt_next
);

    localparam int RW = (RAMP_PERIOD_MS > 1) ? $clog2(RAMP_PERIOD_MS) : 1;

    logic [TILT_W-1:0] r_tilt, n_tilt;
    logic [RW-1:0]     r_ramp_wait, n_ramp_wait;
    logic [TILT_W-1:0] target;
    logic [TILT_W-1:0] step;
    logic [TILT_W-1:0] gap;

    assign target = table_entry(i_tilt_table, {1'b0, i_tilt_index});
    assign step   = {{(TILT_W-STEP_W){1'b0}}, i_ramp_step};

    always_comb begin
        n_tilt      = r_tilt;
        n_ramp_wait = r_ramp_wait;
        gap         = '0;
        if (i_adv) begin
            if (r_ramp_wait == '0) begin
                n_ramp_wait = RW'(RAMP_PERIOD_MS - 1);
                if (target > r_tilt) begin
                    gap    = target - r_tilt;
                    n_tilt = (gap < step) ? target : r_tilt + step;
                end else if (target < r_tilt) begin
                    gap    = r_tilt - target;
                    n_tilt = (gap < step) ? target : r_tilt - step;
                end
            end else begin
                n_ramp_wait = r_ramp_wait - RW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tilt      <= RST_TILT;
            r_ramp_wait <= '0;
        end else begin
            r_tilt      <= n_tilt;
            r_ramp_wait <= n_ramp_wait;
        end
    end

    assign o_tilt_next = n_tilt;

endmodule

FILE: sv/ctps_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctps_seq
// Shot phase machine: tilt wait, shutter, after-shot, index advance, pan.
// ----------------------------------------------------------------------------
module ctps_seq import ctps_pkg::*; #(
    parameter int TILT_POSITIONS = TILT_POSITIONS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  t_cfg                 i_cfg,
    input  logic [TILT_W-1:0]    i_tilt_next,
    output logic [TBL_IDX_W-1:0] o_tilt_index,
    output t_shot_view           o_view_next
);

    typedef enum logic [PHASE_W-1:0] {
        PH_TILT     = 3'd0,
        PH_SHOOT    = 3'd1,
        PH_END_SHOT = 3'd2,
        PH_AFTER    = 3'd3,
        PH_PAN      = 3'd4,
        PH_PAN_END  = 3'd5
    } t_phase;

    t_phase               r_phase, n_phase;
    logic [TBL_IDX_W-1:0] r_idx, n_idx;
    logic [MS_W-1:0]      r_wait, n_wait;
    logic                 r_shutter, n_shutter;
    logic [PULSE_W-1:0]   r_pan, n_pan;
    logic [POS_W-1:0]     idx_inc;

    assign idx_inc = {1'b0, r_idx} + POS_W'(1);

    always_comb begin
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_wait    = r_wait;
        n_shutter = r_shutter;
        n_pan     = r_pan;
        if (i_adv) begin
            if (r_wait != '0) begin
                n_wait = r_wait - MS_W'(1);
            end else begin
                case (r_phase)
                    PH_TILT: begin
                        if (table_entry(i_cfg.tilt_table, {1'b0, r_idx}) == i_tilt_next) begin
                            n_phase = PH_SHOOT;
                            n_wait  = set_wait(i_cfg.settle_pause_ms);
                        end else begin
                            n_wait  = set_wait(POLL_MS);
                        end
                    end
                    PH_SHOOT: begin
                        n_shutter = 1'b1;
                        n_phase   = PH_END_SHOT;
                        n_wait    = set_wait(i_cfg.shutter_ms);
                    end
                    PH_END_SHOT: begin
                        n_shutter = 1'b0;
                        n_phase   = PH_AFTER;
                        n_wait    = set_wait(i_cfg.after_shot_ms);
                    end
                    PH_AFTER: begin
                        if (idx_inc >= POS_W'(TILT_POSITIONS) ||
                            table_entry(i_cfg.tilt_table, idx_inc) == '0) begin
                            n_phase = PH_PAN;
                            n_idx   = '0;
                        end else begin
                            n_phase = PH_TILT;
                            n_idx   = idx_inc[TBL_IDX_W-1:0];
                        end
                    end
                    PH_PAN: begin
                        n_pan   = i_cfg.pan_drive_us;
                        n_phase = PH_PAN_END;
                        n_wait  = set_wait(i_cfg.pan_ms);
                    end
                    PH_PAN_END: begin
                        n_pan   = i_cfg.pan_neutral_us;
                        n_phase = PH_TILT;
                        n_wait  = set_wait(i_cfg.settle_pause_ms);
                    end
                    default: begin
                        n_phase = PH_TILT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_TILT;
            r_idx     <= '0;
            r_wait    <= '0;
            r_shutter <= 1'b0;
            r_pan     <= RST_PAN_NEUTRAL;
        end else begin
            r_phase   <= n_phase;
            r_idx     <= n_idx;
            r_wait    <= n_wait;
            r_shutter <= n_shutter;
            r_pan     <= n_pan;
        end
    end

    assign o_tilt_index        = r_idx;
    assign o_view_next.pan_us  = n_pan;
    assign o_view_next.shutter = n_shutter;
    assign o_view_next.phase   = n_phase;

endmodule

FILE: sv/camera_tilt_pan_shot_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_tilt_pan_shot_sequencer_core
// Tilt ramp and shot/pan phase sequencer, one word per millisecond tick.
// ----------------------------------------------------------------------------
// Usage:
//  - i_tick_chan: one word per millisecond; tick = 1 advances time, tick = 0
//    only reports the current state.
//  - o_shot_chan: one result word per input word, showing tilt and pan pulse
//    widths, shutter line and phase after that tick's update.
//  - i_cfg_chan: register writes (index, data), always ready; write only while
//    the block is idle. New table or neutral values act through the ramp and
//    the phase machine, never by reloading the outputs.
//  - Latency: the result word is valid the cycle after the tick word is taken.
//  - Throughput: one word per cycle when not stalled; a single short pass
//    (ramp compare/step, then phase machine) updates the state registers.
//  - Reset: registers take their default values, phase 0, tilt at table entry
//    0, pan at neutral, result register empty.
//  - Stall: the result register holds its word while o_shot_chan.ready is
//    low; a new tick is taken whenever the result register is empty or is
//    being emptied in the same cycle.
// ----------------------------------------------------------------------------
module camera_tilt_pan_shot_sequencer_core import ctps_pkg::*; #(
    parameter int TILT_POSITIONS = TILT_POSITIONS_DEF,
    parameter int RAMP_PERIOD_MS = RAMP_PERIOD_MS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ctps_tick_if.sink  i_tick_chan,
    ctps_shot_if.source o_shot_chan,
    ctps_cfg_if.sink   i_cfg_chan
);

    // configuration registers
    t_cfg r_cfg;

    // result register
    logic              r_out_valid;
    logic [TILT_W-1:0] r_out_tilt;
    t_shot_view        r_out_view;

    logic                 in_ready;
    logic                 accept;
    logic                 adv;
    logic [TILT_W-1:0]    tilt_next;
    logic [TBL_IDX_W-1:0] tilt_index;
    t_shot_view           view_next;

    // take a tick whenever the result slot is free or draining
    assign in_ready           = !r_out_valid || o_shot_chan.ready;
    assign i_tick_chan.ready  = in_ready;
    assign accept             = i_tick_chan.valid && in_ready;
    assign adv                = accept && i_tick_chan.tick;

    assign i_cfg_chan.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tilt_table      <= RST_TILT_TABLE;
            r_cfg.ramp_step       <= RST_RAMP_STEP;
            r_cfg.settle_pause_ms <= RST_SETTLE_PAUSE;
            r_cfg.shutter_ms      <= RST_SHUTTER;
            r_cfg.after_shot_ms   <= RST_AFTER_SHOT;
            r_cfg.pan_drive_us    <= RST_PAN_DRIVE;
            r_cfg.pan_ms          <= RST_PAN_MS;
            r_cfg.pan_neutral_us  <= RST_PAN_NEUTRAL;
        end else if (i_cfg_chan.valid) begin
            case (i_cfg_chan.index)
                REG_TILT_TABLE:   r_cfg.tilt_table      <= i_cfg_chan.data[TBL_W-1:0];
                REG_RAMP_STEP:    r_cfg.ramp_step       <= i_cfg_chan.data[STEP_W-1:0];
                REG_SETTLE_PAUSE: r_cfg.settle_pause_ms <= i_cfg_chan.data[MS_W-1:0];
                REG_SHUTTER:      r_cfg.shutter_ms      <= i_cfg_chan.data[MS_W-1:0];
                REG_AFTER_SHOT:   r_cfg.after_shot_ms   <= i_cfg_chan.data[MS_W-1:0];
                REG_PAN_DRIVE:    r_cfg.pan_drive_us    <= i_cfg_chan.data[PULSE_W-1:0];
                REG_PAN_MS:       r_cfg.pan_ms          <= i_cfg_chan.data[MS_W-1:0];
                REG_PAN_NEUTRAL:  r_cfg.pan_neutral_us  <= i_cfg_chan.data[PULSE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ramp runs first in a tick; the phase machine sees the new tilt
    ctps_ramp #(
        .RAMP_PERIOD_MS (RAMP_PERIOD_MS)
    ) u_ramp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_tilt_table (r_cfg.tilt_table),
        .i_ramp_step  (r_cfg.ramp_step),
        .i_tilt_index (tilt_index),
        .o_tilt_next  (tilt_next)
    );

    ctps_seq #(
        .TILT_POSITIONS (TILT_POSITIONS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_cfg        (r_cfg),
        .i_tilt_next  (tilt_next),
        .o_tilt_index (tilt_index),
        .o_view_next  (view_next)
    );

    // result register: control under reset, payload loaded on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_ready) begin
            r_out_valid <= i_tick_chan.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_tilt <= tilt_next;
            r_out_view <= view_next;
        end
    end

    assign o_shot_chan.valid         = r_out_valid;
    assign o_shot_chan.tilt_pulse_us = r_out_tilt;
    assign o_shot_chan.pan_pulse_us  = r_out_view.pan_us;
    assign o_shot_chan.shutter_on    = r_out_view.shutter;
    assign o_shot_chan.phase         = r_out_view.phase;

endmodule
